FILE: sv/bfsc_pkg.sv
package bfsc_pkg;

  localparam int unsigned MAX_IMAGE_WIDTH_DEF  = 256;
  localparam int unsigned MAX_IMAGE_HEIGHT_DEF = 256;
  localparam int unsigned MAX_SAMPLES_DEF      = 4;
  localparam int unsigned CHECK_CELL_DEF       = 8;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SURROUND     = 3'd5;

  // sample count per axis, dimension compare width, source position product
  localparam int unsigned NS_W  = 4;
  localparam int unsigned DIM_W = 13;
  localparam int unsigned U0_W  = 50;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CHECK_LIGHT = 8'd255;
  localparam logic [7:0] CHECK_DARK  = 8'd205;

  typedef struct packed {
    logic [23:0] inv_scale;
    logic [22:0] offset_x;
    logic [22:0] offset_y;
    logic [8:0]  image_width;
    logic [8:0]  image_height;
    logic [23:0] surround_color;
  } cfg_t;

  typedef struct packed {
    logic            is_render;
    logic            blank;
    logic            dark;
    logic [NS_W-1:0] n;
    logic [U0_W-1:0] u0x;
    logic [U0_W-1:0] u0y;
    logic [7:0]      src_x;
    logic [7:0]      src_y;
    logic [31:0]     pixel;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // ceil(2^32 / n): exact floor(b / n) as (b * recip(n)) >> 32 for narrow b
  function automatic logic [32:0] recip(input logic [NS_W-1:0] n);
    logic [32:0] r;
    case (n)
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655766;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993460;
      4'd6:    r = 33'd715827883;
      4'd7:    r = 33'd613566757;
      4'd8:    r = 33'd536870912;
      default: r = 33'd4294967296;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/bfsc_front.sv
module bfsc_front #(
  parameter int unsigned MAX_IMAGE_WIDTH  = bfsc_pkg::MAX_IMAGE_WIDTH_DEF,
  parameter int unsigned MAX_IMAGE_HEIGHT = bfsc_pkg::MAX_IMAGE_HEIGHT_DEF,
  parameter int unsigned MAX_SAMPLES      = bfsc_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned CHECK_CELL       = bfsc_pkg::CHECK_CELL_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               mode_i,
  input  logic [7:0]         src_x_i,
  input  logic [7:0]         src_y_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  input  logic [7:0]         alpha_i,
  input  logic [9:0]         dst_x_i,
  input  logic [9:0]         dst_y_i,
  input  bfsc_pkg::cfg_t     cfg_i,
  input  bfsc_pkg::q_stat_t  q_stat_i,
  output logic               push_o,
  output bfsc_pkg::cmd_t     cmd_o
);

  localparam int unsigned CELL_SH  = 22;
  localparam logic [22:0] CELL_RCP = 23'((2 ** CELL_SH + CHECK_CELL - 1) / CHECK_CELL);

  function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
    logic [16:0] t;
    logic [17:0] s;
    t = 17'(c * a) + 17'd128;
    s = {1'b0, t} + 18'(t >> 8);
    return s[15:8];
  endfunction

  logic            stg_v_q, stg_v_d;
  bfsc_pkg::cmd_t  stg_q, cmd_d;
  logic            accept, keep;

  logic signed [24:0] dfx, dfy;
  logic signed [49:0] u0x, u0y;
  logic [32:0]        cx, cy;
  logic [8:0]         nc;
  logic [bfsc_pkg::NS_W-1:0] n;

  assign push_o = stg_v_q & ~q_stat_i.full;
  assign busy   = stg_v_q & q_stat_i.full;
  assign accept = start & ~busy;
  assign cmd_o  = stg_q;

  assign dfx = $signed({7'b0, dst_x_i, 8'b0}) - 25'($signed(cfg_i.offset_x));
  assign dfy = $signed({7'b0, dst_y_i, 8'b0}) - 25'($signed(cfg_i.offset_y));
  assign u0x = dfx * $signed({1'b0, cfg_i.inv_scale});
  assign u0y = dfy * $signed({1'b0, cfg_i.inv_scale});

  // checker cell parity from the reciprocal of the cell size
  assign cx = 33'(dst_x_i * CELL_RCP);
  assign cy = 33'(dst_y_i * CELL_RCP);

  assign nc = 9'((25'(cfg_i.inv_scale) + 25'd65535) >> 16);

  always_comb begin
    if (nc == 9'd0) begin
      n = bfsc_pkg::NS_W'(1);
    end else if (32'(nc) > 32'(MAX_SAMPLES)) begin
      n = bfsc_pkg::NS_W'(MAX_SAMPLES);
    end else begin
      n = bfsc_pkg::NS_W'(nc);
    end
  end

  always_comb begin
    cmd_d.is_render = mode_i;
    cmd_d.blank     = (cfg_i.image_width == 9'd0) | (cfg_i.image_height == 9'd0) |
                      (cfg_i.inv_scale == 24'd0);
    cmd_d.dark      = cx[CELL_SH] ^ cy[CELL_SH];
    cmd_d.n         = n;
    cmd_d.u0x       = u0x;
    cmd_d.u0y       = u0y;
    cmd_d.src_x     = src_x_i;
    cmd_d.src_y     = src_y_i;
    cmd_d.pixel     = {premul(red_i, alpha_i), premul(green_i, alpha_i),
                       premul(blue_i, alpha_i), alpha_i};
    // drop loads that fall outside the store
    keep = mode_i | ((32'(src_x_i) < 32'(MAX_IMAGE_WIDTH)) &
                     (32'(src_y_i) < 32'(MAX_IMAGE_HEIGHT)));
  end

  always_comb begin
    stg_v_d = stg_v_q & ~push_o;
    if (accept) begin
      stg_v_d = keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
    end else begin
      stg_v_q <= stg_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q <= cmd_d;
    end
  end

endmodule

FILE: sv/bfsc_queue.sv
module bfsc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bfsc_pkg::cmd_t     cmd_i,
  input  logic               pop_i,
  output bfsc_pkg::cmd_t     head_o,
  output bfsc_pkg::q_stat_t  stat_o
);

  bfsc_pkg::cmd_t ent_q [bfsc_pkg::QDEPTH];
  logic [bfsc_pkg::QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [bfsc_pkg::QCNT_W-1:0] cnt_q, cnt_d;

  assign head_o       = ent_q[rd_q];
  assign stat_o.full  = (cnt_q == bfsc_pkg::QCNT_W'(bfsc_pkg::QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == bfsc_pkg::QPTR_W'(bfsc_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == bfsc_pkg::QPTR_W'(bfsc_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= cmd_i;
    end
  end

endmodule

FILE: sv/bfsc_back.sv
module bfsc_back #(
  parameter int unsigned MAX_IMAGE_WIDTH  = bfsc_pkg::MAX_IMAGE_WIDTH_DEF,
  parameter int unsigned MAX_IMAGE_HEIGHT = bfsc_pkg::MAX_IMAGE_HEIGHT_DEF,
  parameter int unsigned MAX_SAMPLES      = bfsc_pkg::MAX_SAMPLES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bfsc_pkg::cfg_t     cfg_i,
  input  bfsc_pkg::q_stat_t  q_stat_i,
  input  bfsc_pkg::cmd_t     head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  output logic [7:0]         out_red_o,
  output logic [7:0]         out_green_o,
  output logic [7:0]         out_blue_o,
  output logic               from_image_o
);

  localparam int unsigned MAXD   = (MAX_IMAGE_WIDTH > MAX_IMAGE_HEIGHT) ?
                                   MAX_IMAGE_WIDTH : MAX_IMAGE_HEIGHT;
  localparam int unsigned XW     = (MAX_IMAGE_WIDTH > 1) ? $clog2(MAX_IMAGE_WIDTH) : 1;
  localparam int unsigned YW     = (MAX_IMAGE_HEIGHT > 1) ? $clog2(MAX_IMAGE_HEIGHT) : 1;
  localparam int unsigned DEPTH  = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned BS_W   = $clog2(MAX_SAMPLES * MAXD + 1);
  localparam int unsigned T_MAX  = MAX_SAMPLES * MAX_SAMPLES;
  localparam int unsigned T_W    = $clog2(T_MAX + 1);
  localparam int unsigned SUM_W  = $clog2(255 * T_MAX + 1);
  localparam int unsigned NUM_W  = $clog2(4 * 65025 * T_MAX + 255 * T_MAX + 1);
  localparam int unsigned QT_W   = 10;
  localparam int unsigned DV_W   = NUM_W + QT_W;
  localparam int unsigned A_W    = 57;
  localparam int unsigned NS_W   = bfsc_pkg::NS_W;
  localparam int unsigned DIM_W  = bfsc_pkg::DIM_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_PREP  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]      state_q, state_d;
  bfsc_pkg::cmd_t  cur_q;
  logic            cur_we;
  logic [NS_W-1:0] i_q, i_d, j_q, j_d;

  logic            s1_v_q, s1_v_d, s1_ok_q;
  logic [BS_W-1:0] s1_bx_q, s1_by_q;
  logic            s2_v_q, s2_ok_q;
  logic [XW-1:0]   s2_qx_q;
  logic [YW-1:0]   s2_qy_q;
  logic            s3_v_q;
  logic [31:0]     rd_q;

  logic [31:0]     mem [DEPTH];
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;

  logic [SUM_W-1:0] sr_q, sr_d, sg_q, sg_d, sb_q, sb_d, sa_q, sa_d;
  logic [T_W-1:0]   t_q, t_d;
  logic [DV_W-1:0]  rr_q, rr_d, rg_q, rg_d, rb_q, rb_d, dsh_q, dsh_d;
  logic [QT_W-1:0]  qr_q, qr_d, qg_q, qg_d, qb_q, qb_d;
  logic [3:0]       k_q, k_d;

  logic       out_v_q, out_v_d, out_f_q, out_f_d;
  logic [7:0] out_r_q, out_r_d, out_g_q, out_g_d, out_b_q, out_b_d;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic [16:0]      nw, nh;
  logic [4:0]       n2, odd_x, odd_y;
  logic signed [A_W-1:0] mx, my, ax, ay;
  logic [31:0]      bx, by;
  logic             ok_x, ok_y, last_i, last_j;
  logic [32:0]      rcp;
  logic [BS_W+32:0] px, py;

  logic [NUM_W-1:0] t255, resid, basev, nr, ng, nb;

  // saturate the image size at the store bounds
  assign w_eff = (DIM_W'(cfg_i.image_width) > DIM_W'(MAX_IMAGE_WIDTH)) ?
                 DIM_W'(MAX_IMAGE_WIDTH) : DIM_W'(cfg_i.image_width);
  assign h_eff = (DIM_W'(cfg_i.image_height) > DIM_W'(MAX_IMAGE_HEIGHT)) ?
                 DIM_W'(MAX_IMAGE_HEIGHT) : DIM_W'(cfg_i.image_height);
  assign nw = 17'(cur_q.n * w_eff);
  assign nh = 17'(cur_q.n * h_eff);

  // sample k sits at floor((u0*2n + (2k+1)*inv*256) / (2n * 2^24))
  assign n2    = {cur_q.n, 1'b0};
  assign odd_x = {i_q, 1'b1};
  assign odd_y = {j_q, 1'b1};
  assign mx = $signed(cur_q.u0x) * $signed({1'b0, n2});
  assign my = $signed(cur_q.u0y) * $signed({1'b0, n2});
  assign ax = mx + $signed({{(A_W - 37){1'b0}}, 29'(odd_x * cfg_i.inv_scale), 8'b0});
  assign ay = my + $signed({{(A_W - 37){1'b0}}, 29'(odd_y * cfg_i.inv_scale), 8'b0});
  assign bx = ax[A_W-1:25];
  assign by = ay[A_W-1:25];
  assign ok_x = ~bx[31] & (bx < {15'b0, nw});
  assign ok_y = ~by[31] & (by < {15'b0, nh});
  assign last_i = (i_q == cur_q.n - 1'b1);
  assign last_j = (j_q == cur_q.n - 1'b1);

  // finish the divide by n through its reciprocal
  assign rcp = bfsc_pkg::recip(cur_q.n);
  assign px  = s1_bx_q * rcp;
  assign py  = s1_by_q * rcp;

  assign mem_waddr = AW'(head_i.src_y * MAX_IMAGE_WIDTH) + AW'(head_i.src_x);
  assign mem_raddr = AW'(s2_qy_q * MAX_IMAGE_WIDTH) + AW'(s2_qx_q);
  assign mem_re    = s2_v_q & s2_ok_q;

  assign t255  = NUM_W'(t_q) * NUM_W'(255);
  assign resid = t255 - NUM_W'(sa_q);
  assign basev = NUM_W'(cur_q.dark ? bfsc_pkg::CHECK_DARK : bfsc_pkg::CHECK_LIGHT);
  assign nr    = NUM_W'(sr_q) * NUM_W'(255) + basev * resid;
  assign ng    = NUM_W'(sg_q) * NUM_W'(255) + basev * resid;
  assign nb    = NUM_W'(sb_q) * NUM_W'(255) + basev * resid;

  function automatic logic [7:0] clamp8(input logic [QT_W-1:0] q);
    return (q > QT_W'(255)) ? 8'd255 : q[7:0];
  endfunction

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    cur_we  = 1'b0;
    mem_we  = 1'b0;
    i_d     = i_q;
    j_d     = j_q;
    s1_v_d  = 1'b0;
    sr_d    = sr_q;
    sg_d    = sg_q;
    sb_d    = sb_q;
    sa_d    = sa_q;
    t_d     = t_q;
    rr_d    = rr_q;
    rg_d    = rg_q;
    rb_d    = rb_q;
    dsh_d   = dsh_q;
    qr_d    = qr_q;
    qg_d    = qg_q;
    qb_d    = qb_q;
    k_d     = k_q;
    out_v_d = 1'b0;
    out_f_d = out_f_q;
    out_r_d = out_r_q;
    out_g_d = out_g_q;
    out_b_d = out_b_q;

    if (s3_v_q) begin
      sr_d = sr_q + SUM_W'(rd_q[31:24]);
      sg_d = sg_q + SUM_W'(rd_q[23:16]);
      sb_d = sb_q + SUM_W'(rd_q[15:8]);
      sa_d = sa_q + SUM_W'(rd_q[7:0]);
      t_d  = t_q + 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          if (!head_i.is_render) begin
            mem_we = 1'b1;
          end else if (head_i.blank) begin
            out_v_d = 1'b1;
            out_f_d = 1'b0;
            out_r_d = cfg_i.surround_color[23:16];
            out_g_d = cfg_i.surround_color[15:8];
            out_b_d = cfg_i.surround_color[7:0];
          end else begin
            cur_we  = 1'b1;
            i_d     = '0;
            j_d     = '0;
            sr_d    = '0;
            sg_d    = '0;
            sb_d    = '0;
            sa_d    = '0;
            t_d     = '0;
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        s1_v_d = 1'b1;
        if (last_i) begin
          i_d = '0;
          j_d = j_q + 1'b1;
          if (last_j) begin
            state_d = ST_DRAIN;
          end
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!s1_v_q && !s2_v_q && !s3_v_q) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        if (t_q == '0) begin
          out_v_d = 1'b1;
          out_f_d = 1'b0;
          out_r_d = cfg_i.surround_color[23:16];
          out_g_d = cfg_i.surround_color[15:8];
          out_b_d = cfg_i.surround_color[7:0];
          state_d = ST_IDLE;
        end else begin
          // round half up: (2*num + den) / (2*den)
          rr_d    = DV_W'({nr, 1'b0} + t255);
          rg_d    = DV_W'({ng, 1'b0} + t255);
          rb_d    = DV_W'({nb, 1'b0} + t255);
          dsh_d   = DV_W'({t255, 1'b0}) << (QT_W - 1);
          k_d     = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rr_q >= dsh_q) begin
          rr_d = rr_q - dsh_q;
          qr_d = {qr_q[QT_W-2:0], 1'b1};
        end else begin
          qr_d = {qr_q[QT_W-2:0], 1'b0};
        end
        if (rg_q >= dsh_q) begin
          rg_d = rg_q - dsh_q;
          qg_d = {qg_q[QT_W-2:0], 1'b1};
        end else begin
          qg_d = {qg_q[QT_W-2:0], 1'b0};
        end
        if (rb_q >= dsh_q) begin
          rb_d = rb_q - dsh_q;
          qb_d = {qb_q[QT_W-2:0], 1'b1};
        end else begin
          qb_d = {qb_q[QT_W-2:0], 1'b0};
        end
        dsh_d = dsh_q >> 1;
        k_d   = k_q + 1'b1;
        if (k_q == 4'(QT_W - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        out_v_d = 1'b1;
        out_f_d = 1'b1;
        out_r_d = clamp8(qr_q);
        out_g_d = clamp8(qg_q);
        out_b_d = clamp8(qb_q);
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      k_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= mem_re;
      k_q     <= k_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_q <= head_i;
    end
    s1_ok_q <= ok_x & ok_y;
    s1_bx_q <= bx[BS_W-1:0];
    s1_by_q <= by[BS_W-1:0];
    s2_ok_q <= s1_ok_q;
    s2_qx_q <= px[XW+31:32];
    s2_qy_q <= py[YW+31:32];
    sr_q    <= sr_d;
    sg_q    <= sg_d;
    sb_q    <= sb_d;
    sa_q    <= sa_d;
    t_q     <= t_d;
    rr_q    <= rr_d;
    rg_q    <= rg_d;
    rb_q    <= rb_d;
    dsh_q   <= dsh_d;
    qr_q    <= qr_d;
    qg_q    <= qg_d;
    qb_q    <= qb_d;
    out_f_q <= out_f_d;
    out_r_q <= out_r_d;
    out_g_q <= out_g_d;
    out_b_q <= out_b_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= head_i.pixel;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_red_o    = out_r_q;
  assign out_green_o  = out_g_q;
  assign out_blue_o   = out_b_q;
  assign from_image_o = out_f_q;

endmodule

FILE: sv/box_filter_scaler_checker_composite.sv
// Box-filter image scaler, composited over a light/dark checker.
//
// Input channel: an item is taken at a clock edge with start high and busy
// low. mode_i = 0 loads one source pixel (premultiplied on entry, no
// result); mode_i = 1 renders one destination pixel (exactly one result).
// Result channel: out_valid_o is high for one cycle per render item and the
// result must be taken in that cycle; the receiver cannot stall the block.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i on the
// same edge; write it only while no render is in flight.
//
// Timing: a front stage takes items every cycle while busy is low, into a
// two-entry queue; busy rises only while the queue and front stage are full.
// The back end writes a load to the store from its idle state. A render
// with n x n samples (n = clamp(ceil(inv_scale / 2^16), 1, MAX_SAMPLES))
// reads the source memory once per in-image sample, then runs a ten-step
// restoring divider; a blank render (no image or zero scale) gets the
// surround from idle. Reset clears control state and config, but sets
// inv_scale to 65536; the source memory holds garbage until written.
module box_filter_scaler_checker_composite #(
  parameter int unsigned MAX_IMAGE_WIDTH  = bfsc_pkg::MAX_IMAGE_WIDTH_DEF,
  parameter int unsigned MAX_IMAGE_HEIGHT = bfsc_pkg::MAX_IMAGE_HEIGHT_DEF,
  parameter int unsigned MAX_SAMPLES      = bfsc_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned CHECK_CELL       = bfsc_pkg::CHECK_CELL_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            mode_i,
  input  logic [7:0]                      src_x_i,
  input  logic [7:0]                      src_y_i,
  input  logic [7:0]                      red_i,
  input  logic [7:0]                      green_i,
  input  logic [7:0]                      blue_i,
  input  logic [7:0]                      alpha_i,
  input  logic [9:0]                      dst_x_i,
  input  logic [9:0]                      dst_y_i,
  input  logic                            cfg_we_i,
  input  logic [bfsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bfsc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                            out_valid_o,
  output logic [7:0]                      out_red_o,
  output logic [7:0]                      out_green_o,
  output logic [7:0]                      out_blue_o,
  output logic                            from_image_o
);

  bfsc_pkg::cfg_t    cfg_q, cfg_d;
  bfsc_pkg::q_stat_t q_stat;
  bfsc_pkg::cmd_t    push_cmd, head_cmd;
  logic              push, pop;

  // Config register file; an index past the list is dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        bfsc_pkg::CFG_INV_SCALE:    cfg_d.inv_scale      = cfg_wdata_i;
        bfsc_pkg::CFG_OFFSET_X:     cfg_d.offset_x       = cfg_wdata_i[22:0];
        bfsc_pkg::CFG_OFFSET_Y:     cfg_d.offset_y       = cfg_wdata_i[22:0];
        bfsc_pkg::CFG_IMAGE_WIDTH:  cfg_d.image_width    = cfg_wdata_i[8:0];
        bfsc_pkg::CFG_IMAGE_HEIGHT: cfg_d.image_height   = cfg_wdata_i[8:0];
        bfsc_pkg::CFG_SURROUND:     cfg_d.surround_color = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_scale      <= 24'd65536;
      cfg_q.offset_x       <= '0;
      cfg_q.offset_y       <= '0;
      cfg_q.image_width    <= '0;
      cfg_q.image_height   <= '0;
      cfg_q.surround_color <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: take the item, premultiply loads, map renders into source space.
  bfsc_front #(
    .MAX_IMAGE_WIDTH  (MAX_IMAGE_WIDTH),
    .MAX_IMAGE_HEIGHT (MAX_IMAGE_HEIGHT),
    .MAX_SAMPLES      (MAX_SAMPLES),
    .CHECK_CELL       (CHECK_CELL)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .mode_i   (mode_i),
    .src_x_i  (src_x_i),
    .src_y_i  (src_y_i),
    .red_i    (red_i),
    .green_i  (green_i),
    .blue_i   (blue_i),
    .alpha_i  (alpha_i),
    .dst_x_i  (dst_x_i),
    .dst_y_i  (dst_y_i),
    .cfg_i    (cfg_q),
    .q_stat_i (q_stat),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // Queue: decouple the front from the sampling back end.
  bfsc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head_cmd),
    .stat_o (q_stat)
  );

  // Back: write the store, or sample, average and blend one pixel.
  bfsc_back #(
    .MAX_IMAGE_WIDTH  (MAX_IMAGE_WIDTH),
    .MAX_IMAGE_HEIGHT (MAX_IMAGE_HEIGHT),
    .MAX_SAMPLES      (MAX_SAMPLES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_stat_i     (q_stat),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .from_image_o (from_image_o)
  );

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("item pushed into a full queue");

  a_busy_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> q_stat.full)
    else $error("busy raised while the queue has room");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("item popped from an empty queue");
`endif

endmodule

FILE: verif/box_filter_scaler_checker_composite_tb.sv
module box_filter_scaler_checker_composite_tb;

  // Register indexes past the end of the map; writes to them must be ignored.
  localparam logic [bfsc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [bfsc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_RENDER = 1'b1;
  localparam int   SETTLE_CYCLES = 60;  // longest render path plus queue depth

  typedef struct {
    logic       mode;
    logic [7:0] sx, sy, r, g, b, a;
    logic [9:0] dx, dy;
  } item_t;

  typedef struct {
    logic [7:0] r, g, b;
    logic       fi;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic mode_i = 1'b0;
  logic [7:0] src_x_i = '0, src_y_i = '0, red_i = '0, green_i = '0, blue_i = '0;
  logic [7:0] alpha_i = '0;
  logic [9:0] dst_x_i = '0, dst_y_i = '0;
  logic cfg_we_i = 1'b0;
  logic [bfsc_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [bfsc_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic out_valid_o, from_image_o;
  logic [7:0] out_red_o, out_green_o, out_blue_o;

  box_filter_scaler_checker_composite u_dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .src_x_i, .src_y_i, .red_i,
    .green_i, .blue_i, .alpha_i, .dst_x_i, .dst_y_i, .cfg_we_i, .cfg_idx_i,
    .cfg_wdata_i, .out_valid_o, .out_red_o, .out_green_o, .out_blue_o,
    .from_image_o
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the block state, advanced in issue order.
  logic [31:0] pix_mem [65536];
  bit          written [65536];
  longint      sh_inv = 65536, sh_ox = 0, sh_oy = 0, sh_w = 0, sh_h = 0;
  logic [23:0] sh_sur = '0;

  item_t  pending_items[$];
  pixel_t pixels_due[$];
  int     errors = 0;
  int     cyc = 0;

  function automatic longint src_index(longint p, longint off, longint n, longint k);
    longint num, den;
    num = (p * 256 - off) * sh_inv * 2 * n + (2 * k + 1) * sh_inv * 256;
    den = (2 * n) << 24;
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic logic [7:0] over_checker(longint sc, longint sa, longint t, longint base);
    longint den, num, v;
    den = 255 * t;
    num = 255 * sc + base * (255 * t - sa);
    v = (2 * num + den) / (2 * den);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // Returns 0 when the render would touch a never-written store entry.
  function automatic bit shade_pixel(input longint dx, dy, output pixel_t px);
    longint w, h, n, sx, sy, sr, sg, sb, sa, t, base;
    logic [31:0] q;
    w = (sh_w > 256) ? 256 : sh_w;
    h = (sh_h > 256) ? 256 : sh_h;
    sr = 0; sg = 0; sb = 0; sa = 0; t = 0;
    if (w != 0 && h != 0 && sh_inv != 0) begin
      n = (sh_inv + 65535) >>> 16;
      if (n < 1) n = 1;
      if (n > 4) n = 4;
      for (longint j = 0; j < n; j++) begin
        sy = src_index(dy, sh_oy, n, j);
        if (sy < 0 || sy >= h) continue;
        for (longint i = 0; i < n; i++) begin
          sx = src_index(dx, sh_ox, n, i);
          if (sx < 0 || sx >= w) continue;
          if (!written[sy * 256 + sx]) return 0;
          q = pix_mem[sy * 256 + sx];
          sr += q[31:24]; sg += q[23:16]; sb += q[15:8]; sa += q[7:0]; t++;
        end
      end
    end
    if (t == 0) begin
      px = '{sh_sur[23:16], sh_sur[15:8], sh_sur[7:0], 1'b0};
    end else begin
      base = ((dx / 8 + dy / 8) % 2 == 1) ? 205 : 255;
      px = '{over_checker(sr, sa, t, base), over_checker(sg, sa, t, base),
             over_checker(sb, sa, t, base), 1'b1};
    end
    return 1;
  endfunction

  function automatic logic [7:0] premul(logic [7:0] c, logic [7:0] a);
    int unsigned v;
    v = (2 * c * a + 255) / 510;
    return v[7:0];
  endfunction

  // Queue a load and record it in the shadow store.
  task automatic push_load(logic [7:0] sx, sy, r, g, b, a);
    item_t it;
    it = '{MODE_LOAD, sx, sy, r, g, b, a, 10'($urandom), 10'($urandom)};
    pix_mem[{sy, sx}] = {premul(r, a), premul(g, a), premul(b, a), a};
    written[{sy, sx}] = 1'b1;
    pending_items.push_back(it);
  endtask

  // Queue a render if it only reads written entries; report whether it did.
  function automatic bit push_render(logic [9:0] dx, dy);
    item_t  it;
    pixel_t px;
    if (!shade_pixel(dx, dy, px)) return 0;
    it = '{MODE_RENDER, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
           8'($urandom), 8'($urandom), dx, dy};
    pending_items.push_back(it);
    pixels_due.push_back(px);
    return 1;
  endfunction

  task automatic rand_load(logic [7:0] sx, sy);
    logic [7:0] a;
    case ($urandom_range(3))
      0: a = 8'd0;
      1: a = 8'd255;
      default: a = 8'($urandom);
    endcase
    push_load(sx, sy, 8'($urandom), 8'($urandom), 8'($urandom), a);
  endtask

  // Destination coordinate whose footprint lands near source index s.
  function automatic logic [9:0] aim(longint s, longint off);
    longint d;
    d = sh_inv == 0 ? 0 : ((s * (64'sd1 << 24) + sh_inv / 2) / sh_inv + off) / 256;
    d += $signed($urandom_range(2)) - 1;
    if (d < 0) d = 0;
    if (d > 1023) d = 1023;
    return d[9:0];
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || start || pixels_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [bfsc_pkg::CFG_IDX_W-1:0] idx,
                           logic [bfsc_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      bfsc_pkg::CFG_INV_SCALE:    sh_inv = data;
      bfsc_pkg::CFG_OFFSET_X:     sh_ox = $signed(data[22:0]);
      bfsc_pkg::CFG_OFFSET_Y:     sh_oy = $signed(data[22:0]);
      bfsc_pkg::CFG_IMAGE_WIDTH:  sh_w = data[8:0];
      bfsc_pkg::CFG_IMAGE_HEIGHT: sh_h = data[8:0];
      bfsc_pkg::CFG_SURROUND:     sh_sur = data[23:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One configuration setting followed by a fill of the visible corner and a
  // random mix of renders and loads.
  task automatic run_phase(longint inv, ox, oy, w, h, logic [23:0] sur, int count);
    longint we, he, fw, fh;
    bit ok;
    wait_idle();
    write_reg(bfsc_pkg::CFG_INV_SCALE, inv[23:0]);
    write_reg(bfsc_pkg::CFG_OFFSET_X, 24'(ox));
    write_reg(bfsc_pkg::CFG_OFFSET_Y, 24'(oy));
    write_reg(bfsc_pkg::CFG_IMAGE_WIDTH, 24'(w));
    write_reg(bfsc_pkg::CFG_IMAGE_HEIGHT, 24'(h));
    write_reg(bfsc_pkg::CFG_SURROUND, sur);
    end_writes();
    we = (w > 256) ? 256 : w;
    he = (h > 256) ? 256 : h;
    fw = (we > 20) ? 20 : we;
    fh = (he > 20) ? 20 : he;
    for (longint y = 0; y < fh; y++)
      for (longint x = 0; x < fw; x++)
        if (!written[y * 256 + x]) rand_load(x[7:0], y[7:0]);
    for (int k = 0; k < count; k++) begin
      ok = 0;
      if ($urandom_range(99) < 25) begin
        if (fw != 0 && $urandom_range(1))
          rand_load(8'($urandom_range(fw - 1)), 8'($urandom_range(fh - 1)));
        else
          rand_load(8'($urandom), 8'($urandom));
        ok = 1;
      end
      for (int tries = 0; tries < 8 && !ok; tries++) begin
        if ($urandom_range(99) < 25)
          ok = push_render(10'($urandom), 10'($urandom));
        else
          ok = push_render(aim($signed($urandom_range(fw + 3)) - 2, ox),
                           aim($signed($urandom_range(fh + 3)) - 2, oy));
      end
      if (!ok) rand_load(8'($urandom_range(19)), 8'($urandom_range(19)));
    end
  endtask

  // Driver: present the next item once the current one is taken.
  always @(posedge clk_i) begin
    item_t it;
    bit    quiet;
    cyc <= cyc + 1;
    quiet = (cyc > 4000 && cyc < 12000);
    if (rst_ni && (!start || !busy)) begin
      if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= 25)) begin
        it = pending_items.pop_front();
        mode_i <= it.mode;
        src_x_i <= it.sx;  src_y_i <= it.sy;
        red_i <= it.r;     green_i <= it.g;
        blue_i <= it.b;    alpha_i <= it.a;
        dst_x_i <= it.dx;  dst_y_i <= it.dy;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed pixel must match the oldest prediction.
  always @(posedge clk_i) begin
    pixel_t px;
    if (rst_ni && out_valid_o) begin
      if (pixels_due.size() == 0) begin
        if (errors < 10) $display("unexpected pixel %h %h %h fi=%b",
                                  out_red_o, out_green_o, out_blue_o, from_image_o);
        errors++;
      end else begin
        px = pixels_due.pop_front();
        if (px.r !== out_red_o || px.g !== out_green_o || px.b !== out_blue_o ||
            px.fi !== from_image_o) begin
          if (errors < 10)
            $display("pixel mismatch: exp %h %h %h fi=%b got %h %h %h fi=%b",
                     px.r, px.g, px.b, px.fi,
                     out_red_o, out_green_o, out_blue_o, from_image_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("box_filter_scaler_checker_composite_tb NOT OK");
    $finish;
  end

  initial begin
    bit ok;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: no image after reset answers the reset surround; load extremes.
    ok = push_render(10'd0, 10'd0);
    ok = push_render(10'd1023, 10'd1023);
    push_load(8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
    push_load(8'd1, 8'd0, 8'd255, 8'd0, 8'd128, 8'd0);
    push_load(8'd0, 8'd1, 8'd0, 8'd255, 8'd1, 8'd128);
    push_load(8'd1, 8'd1, 8'd255, 8'd255, 8'd255, 8'd1);
    push_load(8'd255, 8'd255, 8'd170, 8'd85, 8'd254, 8'd254);
    push_load(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    push_load(8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);

    // Spare indexes must not disturb the live registers.
    wait_idle();
    write_reg(CFG_SPARE_LO, 24'hFFFFFF);
    write_reg(CFG_SPARE_HI, 24'h5A5A5A);
    end_writes();
    ok = push_render(10'd8, 10'd0);

    // 2x2 image at unit scale, then a render on each checker color.
    run_phase(65536, 0, 0, 2, 2, 24'hFFFFFF, 0);
    ok = push_render(10'd0, 10'd0);
    ok = push_render(10'd1, 10'd1);
    ok = push_render(10'd2, 10'd0);
    ok = push_render(10'd8, 10'd0);
    ok = push_render(10'd1023, 10'd0);
    // Zero scale means no image even with a loaded image.
    run_phase(0, 0, 0, 2, 2, 24'h123456, 4);

    run_phase(65536, 0, 0, 16, 16, 24'h00FF00, 90);
    run_phase(4 * 65536, 768, -1024, 12, 10, 24'h000000, 90);
    run_phase(65536 + 1, 300, 200, 9, 7, 24'hA5C3E1, 90);
    run_phase(16777215, 0, 0, 20, 20, 24'hFFFFFF, 90);
    run_phase(1, -4194304, 4194303, 5, 17, 24'h800001, 60);
    run_phase(1, 4194303, -4194304, 1, 1, 24'h7F7F7F, 60);
    run_phase(32768, 4194303, 4194303, 1, 20, 24'h010203, 60);
    run_phase(3 * 65536 / 2, -4194304, -4194304, 20, 3, 24'h3C3C3C, 60);
    run_phase(98304, 2560, 1280, 256, 256, 24'h0F0F0F, 90);
    run_phase(2 * 65536, -3000, 5000, 511, 511, 24'hF0F0F0, 90);
    run_phase(3 * 65536 + 7, 1000, 0, 17, 19, 24'hFEDCBA, 90);
    run_phase(21845, 40, 40, 6, 6, 24'h00000F, 90);

    wait_idle();
    if (pixels_due.size() != 0) errors++;
    if (errors == 0)
      $display("box_filter_scaler_checker_composite_tb OK");
    else
      $display("box_filter_scaler_checker_composite_tb NOT OK");
    $finish;
  end

endmodule
